/* hw/rtl/dsol_pkg.sv */
`default_nettype none
package dsol_pkg;
  localparam int Entries = 64;
  localparam int Lists = 4;
  localparam int IdxW = $clog2(Entries);
  localparam int LinkW = IdxW + 1;
  localparam int ListW = 2;
  localparam int RoleW = 2;
  localparam int CntW = IdxW + 1;
  localparam logic [LinkW-1:0] NilLink = LinkW'(Entries);

  localparam logic [2:0] CmdRebuild = 3'd0;
  localparam logic [2:0] CmdAlloc   = 3'd1;
  localparam logic [2:0] CmdInsert  = 3'd2;
  localparam logic [2:0] CmdDelete  = 3'd3;
  localparam logic [2:0] CmdKeys    = 3'd4;
  localparam logic [2:0] CmdSort    = 3'd5;
  localparam logic [2:0] CmdHead    = 3'd6;
  localparam logic [2:0] CmdNext    = 3'd7;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StEmpty   = 2'd1;
  localparam logic [1:0] StMissing = 2'd2;

  // Memory port requests from controller to datapath.
  typedef enum logic [3:0] {
    OpNone, OpReadCur, OpReadE, OpWriteLink, OpWriteKeys, OpAllocClr,
    OpRebuildStep
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IdxW-1:0]  addr;
    logic [LinkW-1:0] wlink;
  } dp_cmd_t;

  typedef struct packed {
    logic [LinkW-1:0] rlink;
    logic [31:0]      rdepth;
    logic [31:0]      rheight;
  } dp_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/dsol_datapath.sv */
`default_nettype none
module dsol_datapath
  import dsol_pkg::*;
(
  input  wire logic        clk,
  input  wire dp_cmd_t     cmd,
  input  wire logic [31:0] depth_key,
  input  wire logic [31:0] height_key,
  output dp_stat_t         stat
);
  // Link, depth and height memories, one access per cycle, registered read.
  logic [LinkW-1:0] link_mem [Entries];
  logic [31:0]      depth_mem [Entries];
  logic [31:0]      height_mem [Entries];

  always_ff @(posedge clk) begin
    case (cmd.op)
      OpWriteLink: begin
        link_mem[cmd.addr] <= cmd.wlink;
      end
      OpRebuildStep: begin
        link_mem[cmd.addr] <= cmd.wlink;
      end
      OpWriteKeys: begin
        depth_mem[cmd.addr]  <= depth_key;
        height_mem[cmd.addr] <= height_key;
      end
      OpAllocClr: begin
        link_mem[cmd.addr]   <= NilLink;
        depth_mem[cmd.addr]  <= '0;
        height_mem[cmd.addr] <= '0;
      end
      OpReadCur, OpReadE: begin
        stat.rlink   <= link_mem[cmd.addr];
        stat.rdepth  <= depth_mem[cmd.addr];
        stat.rheight <= height_mem[cmd.addr];
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/dsol_ctrl.sv */
`default_nettype none
module dsol_ctrl
  import dsol_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [1:0]  list_select,
  input  wire logic [5:0]  entry_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       result_index,
  output logic             result_present,
  output dp_cmd_t          dcmd,
  input  wire dp_stat_t    dstat
);
  localparam logic [4:0] S_IDLE = 5'd0, S_CLEAR = 5'd1, S_REBUILD = 5'd2,
    S_ALLOC_RD = 5'd3, S_ALLOC_WT = 5'd4, S_NEXT_RD = 5'd5, S_NEXT_WT = 5'd6,
    S_INS_E = 5'd7, S_INS_EW = 5'd8, S_INS_RD = 5'd9, S_INS_WT = 5'd10,
    S_INS_LE = 5'd11, S_INS_LP = 5'd12, S_DEL_RD = 5'd13, S_DEL_WT = 5'd14,
    S_DEL_LP = 5'd15, S_DEL_LE = 5'd16, S_SRT_RD = 5'd17, S_SRT_WT = 5'd18,
    S_SRT_UL = 5'd19, S_DONE = 5'd20, S_CHK = 5'd21;

  localparam logic [RoleW-1:0] RoleFreeC = 2'd0, RoleAllocC = 2'd1, RoleListC = 2'd2;

  logic [4:0]       state;
  logic [2:0]       cmd_q;
  logic [ListW-1:0] lst_q;
  logic [IdxW-1:0]  e_q;
  logic [LinkW-1:0] free_head;
  logic [LinkW-1:0] heads [Lists];
  logic [RoleW-1:0] role [Entries];
  logic [ListW-1:0] role_lst [Entries];
  logic [RoleW-1:0] role_rd;
  logic [ListW-1:0] role_lst_rd;
  logic [CntW-1:0]  cnt;
  logic [LinkW-1:0] prev, cur, e_link, sprev;
  logic [31:0]      e_d, e_h, p_d, p_h;
  logic             sorting;

  logic [IdxW-1:0] cur_i, prev_i;
  assign cur_i  = cur[IdxW-1:0];
  assign prev_i = prev[IdxW-1:0];

  logic e_before_cur, cur_less_prev;
  assign e_before_cur = ($signed(e_d) < $signed(dstat.rdepth)) ||
    (e_d == dstat.rdepth && $signed(e_h) <= $signed(dstat.rheight));
  assign cur_less_prev = (dstat.rdepth != p_d) ? ($signed(dstat.rdepth) < $signed(p_d))
                                               : ($signed(dstat.rheight) < $signed(p_h));

  // A new item waits until the previous result has been taken.
  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    dcmd = '{op: OpNone, addr: '0, wlink: '0};
    case (state)
      S_IDLE: begin
        if (in_valid && !out_valid && command == CmdKeys)
          dcmd = '{op: OpWriteKeys, addr: entry_index, wlink: '0};
      end
      S_CLEAR, S_REBUILD: begin
        dcmd.op = OpRebuildStep;
        dcmd.addr = cnt[IdxW-1:0];
        dcmd.wlink = (cnt == CntW'(Entries - 1)) ? NilLink : LinkW'(cnt + 1'b1);
      end
      S_ALLOC_RD: dcmd = '{op: OpReadCur, addr: free_head[IdxW-1:0], wlink: '0};
      S_ALLOC_WT: dcmd = '{op: OpAllocClr, addr: free_head[IdxW-1:0], wlink: '0};
      S_NEXT_RD, S_INS_E: dcmd = '{op: OpReadE, addr: e_q, wlink: '0};
      S_INS_RD, S_DEL_RD, S_SRT_RD: dcmd = '{op: OpReadCur, addr: cur_i, wlink: '0};
      S_INS_LE: dcmd = '{op: OpWriteLink, addr: e_q, wlink: cur};
      S_INS_LP: dcmd = '{op: OpWriteLink, addr: prev_i, wlink: {1'b0, e_q}};
      S_DEL_LP: dcmd = '{op: OpWriteLink, addr: prev_i, wlink: e_link};
      S_DEL_LE: dcmd = '{op: OpWriteLink, addr: e_q, wlink: free_head};
      S_SRT_UL: dcmd = '{op: OpWriteLink, addr: sprev[IdxW-1:0], wlink: e_link};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
      cnt <= '0;
      free_head <= '0;
      sorting <= 1'b0;
      for (int i = 0; i < Lists; i++) heads[i] <= NilLink;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_q <= command;
            lst_q <= list_select;
            e_q <= entry_index;
            status <= StOk;
            result_index <= '0;
            result_present <= 1'b0;
            sorting <= 1'b0;
            role_rd <= role[entry_index];
            role_lst_rd <= role_lst[entry_index];
            case (command)
              CmdRebuild: begin
                cnt <= '0;
                state <= S_REBUILD;
              end
              CmdAlloc: begin
                if (free_head[IdxW]) begin
                  status <= StEmpty;
                  state <= S_DONE;
                end else begin
                  state <= S_ALLOC_RD;
                end
              end
              CmdInsert, CmdDelete: state <= S_CHK;
              CmdKeys: state <= S_DONE;
              CmdSort: begin
                sorting <= 1'b1;
                sprev <= NilLink;
                cur <= heads[list_select];
                state <= S_SRT_RD;
              end
              CmdHead: begin
                result_index <= heads[list_select][IdxW] ? '0
                                                         : heads[list_select][IdxW-1:0];
                result_present <= !heads[list_select][IdxW];
                state <= S_DONE;
              end
              default: state <= S_NEXT_RD;
            endcase
          end
        end
        S_CHK: begin
          // The entry's membership was read on the accepting edge.
          if (cmd_q == CmdInsert) begin
            if (role_rd != RoleAllocC) begin
              status <= StMissing;
              state <= S_DONE;
            end else begin
              state <= S_INS_E;
            end
          end else if (role_rd != RoleListC || role_lst_rd != lst_q) begin
            status <= StMissing;
            state <= S_DONE;
          end else begin
            prev <= NilLink;
            cur <= heads[lst_q];
            cnt <= '0;
            state <= S_DEL_RD;
          end
        end
        S_CLEAR, S_REBUILD: begin
          role[cnt[IdxW-1:0]] <= RoleFreeC;
          if (cnt == CntW'(Entries - 1)) begin
            free_head <= '0;
            for (int i = 0; i < Lists; i++) heads[i] <= NilLink;
            state <= (state == S_CLEAR) ? S_IDLE : S_DONE;
          end
          cnt <= cnt + 1'b1;
        end
        S_ALLOC_RD: state <= S_ALLOC_WT;
        S_ALLOC_WT: begin
          free_head <= dstat.rlink;
          role[free_head[IdxW-1:0]] <= RoleAllocC;
          result_index <= free_head[IdxW-1:0];
          result_present <= 1'b1;
          state <= S_DONE;
        end
        S_NEXT_RD: state <= S_NEXT_WT;
        S_NEXT_WT: begin
          result_present <= !dstat.rlink[IdxW];
          result_index <= dstat.rlink[IdxW] ? '0 : dstat.rlink[IdxW-1:0];
          state <= S_DONE;
        end
        S_INS_E: state <= S_INS_EW;
        S_INS_EW: begin
          e_d <= dstat.rdepth;
          e_h <= dstat.rheight;
          prev <= NilLink;
          cur <= heads[lst_q];
          cnt <= '0;
          state <= heads[lst_q][IdxW] ? S_INS_LE : S_INS_RD;
        end
        S_INS_RD: state <= S_INS_WT;
        S_INS_WT: begin
          if (e_before_cur) begin
            state <= S_INS_LE;
          end else begin
            prev <= cur;
            cur <= dstat.rlink;
            cnt <= cnt + 1'b1;
            state <= (dstat.rlink[IdxW] || cnt == CntW'(Entries - 1)) ? S_INS_LE : S_INS_RD;
          end
        end
        S_INS_LE: begin
          if (prev[IdxW]) begin
            heads[lst_q] <= {1'b0, e_q};
            if (sorting) begin
              // The moved entry is the new head, so the scan restarts there.
              cur <= {1'b0, e_q};
              sprev <= NilLink;
              state <= S_SRT_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_INS_LP;
          end
          if (!sorting) begin
            role[e_q] <= RoleListC;
            role_lst[e_q] <= lst_q;
          end
        end
        S_INS_LP: begin
          if (sorting) begin
            cur <= heads[lst_q];
            sprev <= NilLink;
            state <= S_SRT_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DEL_RD: state <= S_DEL_WT;
        S_DEL_WT: begin
          if (cur_i == e_q) begin
            e_link <= dstat.rlink;
            if (prev[IdxW]) begin
              heads[lst_q] <= dstat.rlink;
              state <= S_DEL_LE;
            end else begin
              state <= S_DEL_LP;
            end
          end else begin
            prev <= cur;
            cur <= dstat.rlink;
            cnt <= cnt + 1'b1;
            if (dstat.rlink[IdxW] || cnt == CntW'(Entries - 1)) begin
              status <= StMissing;
              state <= S_DONE;
            end else begin
              state <= S_DEL_RD;
            end
          end
        end
        S_DEL_LP: state <= S_DEL_LE;
        S_DEL_LE: begin
          free_head <= {1'b0, e_q};
          role[e_q] <= RoleFreeC;
          state <= S_DONE;
        end
        S_SRT_RD: begin
          if (cur[IdxW]) state <= S_DONE;
          else state <= S_SRT_WT;
        end
        S_SRT_WT: begin
          if (!sprev[IdxW] && cur_less_prev) begin
            e_q <= cur_i;
            e_d <= dstat.rdepth;
            e_h <= dstat.rheight;
            e_link <= dstat.rlink;
            state <= S_SRT_UL;
          end else begin
            sprev <= cur;
            p_d <= dstat.rdepth;
            p_h <= dstat.rheight;
            cur <= dstat.rlink;
            state <= S_SRT_RD;
          end
        end
        S_SRT_UL: begin
          // Entry unlinked; now walk from the head to place it again.
          prev <= NilLink;
          cur <= heads[lst_q];
          cnt <= '0;
          sprev <= NilLink;
          state <= heads[lst_q][IdxW] ? S_INS_LE : S_INS_RD;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/depth_sorted_object_list_pool_core.sv */
`default_nettype none
// Depth-sorted list pool: 64 entries threaded onto a free list and four
// display lists ordered by depth, then height. One command item is taken at
// a time and gives exactly one result item, and the next item is not taken
// until that result has been accepted. Keys, head, next and allocate walk no
// list; insert and delete walk the list one entry at a time through the
// single memory port, and sort restarts its walk after every moved entry,
// so its time grows with how disordered the list is. After reset a pass
// chains every entry onto the free list before the first item is accepted;
// rebuild makes the same pass.
module depth_sorted_object_list_pool_core
  import dsol_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [1:0]  list_select,
  input  wire logic [5:0]  entry_index,
  input  wire logic [31:0] depth_key,
  input  wire logic [31:0] height_key,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       result_index,
  output logic             result_present
);
  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // The controller owns the sequencing; the datapath holds the stores.
  dsol_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .command, .list_select, .entry_index,
    .out_valid, .out_stall, .status, .result_index, .result_present,
    .dcmd, .dstat
  );

  dsol_datapath u_dp (
    .clk, .cmd(dcmd), .depth_key, .height_key, .stat(dstat)
  );
endmodule
`default_nettype wire

/* hw/rtl/dsol_checker.sv */
`default_nettype none
module dsol_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] status,
  input wire logic       result_present
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)) else $error("result dropped");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_present |-> status == 2'd0) else $error("present with error");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("second item taken");
endmodule

bind depth_sorted_object_list_pool_core dsol_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .result_present
);
`default_nettype wire

/* dv/depth_sorted_object_list_pool_checker.sv */
module depth_sorted_object_list_pool_checker
  import dsol_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [1:0]  list_select,
  input  wire logic [5:0]  entry_index,
  input  wire logic [31:0] depth_key,
  input  wire logic [31:0] height_key,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  status,
  input  wire logic [5:0]  result_index,
  input  wire logic        result_present,
  output int               fail_count,
  output int               pending_count
);
  localparam logic [4:0] RoleFree  = 5'd16;
  localparam logic [4:0] RoleAlloc = 5'd17;

  typedef struct packed {
    logic [1:0] st;
    logic [5:0] idx;
    logic       pres;
  } pool_result_t;

  logic [LinkW-1:0] succ [Entries];
  logic signed [31:0] dep [Entries];
  logic signed [31:0] hgt [Entries];
  logic [4:0] owner [Entries];
  logic [LinkW-1:0] free_top;
  logic [LinkW-1:0] heads [Lists];
  pool_result_t awaited_results [$];

  function automatic bit sorts_before(int a, int b);
    if (dep[a] != dep[b]) return dep[a] < dep[b];
    return hgt[a] < hgt[b];
  endfunction

  function automatic void chain_free();
    for (int i = 0; i < Entries; i++) begin
      succ[i] = LinkW'(i + 1);
      owner[i] = RoleFree;
    end
    free_top = '0;
    for (int i = 0; i < Lists; i++) heads[i] = NilLink;
  endfunction

  function automatic void place_sorted(int l, int e);
    int prev;
    int cur;
    int n;
    prev = Entries;
    cur = heads[l];
    n = 0;
    while (cur < Entries && n < Entries) begin
      if (dep[e] < dep[cur]) break;
      if (dep[e] == dep[cur] && hgt[e] <= hgt[cur]) break;
      prev = cur;
      cur = succ[cur];
      n++;
    end
    succ[e] = LinkW'(cur);
    if (prev == Entries) heads[l] = LinkW'(e);
    else succ[prev] = LinkW'(e);
  endfunction

  function automatic void resort_list(int l);
    int prev;
    int cur;
    prev = Entries;
    cur = heads[l];
    while (cur < Entries) begin
      if (prev != Entries && sorts_before(cur, prev)) begin
        succ[prev] = succ[cur];
        place_sorted(l, cur);
        prev = Entries;
        cur = heads[l];
      end else begin
        prev = cur;
        cur = succ[cur];
      end
    end
  endfunction

  function automatic pool_result_t apply_command(logic [2:0] c, int l, int e,
                                                 logic [31:0] dk, logic [31:0] hk);
    pool_result_t r;
    int prev;
    int cur;
    int n;
    int f;
    r = '0;
    r.st = StOk;
    case (c)
      CmdRebuild: chain_free();
      CmdAlloc: begin
        if (free_top >= Entries) r.st = StEmpty;
        else begin
          f = free_top;
          free_top = succ[f];
          succ[f] = NilLink;
          dep[f] = 0;
          hgt[f] = 0;
          owner[f] = RoleAlloc;
          r.idx = 6'(f);
          r.pres = 1'b1;
        end
      end
      CmdInsert: begin
        if (l >= Lists || owner[e] != RoleAlloc) r.st = StMissing;
        else begin
          place_sorted(l, e);
          owner[e] = 5'(l);
        end
      end
      CmdDelete: begin
        if (l >= Lists || owner[e] != 5'(l)) r.st = StMissing;
        else begin
          prev = Entries;
          cur = heads[l];
          n = 0;
          while (cur < Entries && cur != e && n < Entries) begin
            prev = cur;
            cur = succ[cur];
            n++;
          end
          if (cur != e) r.st = StMissing;
          else begin
            if (prev == Entries) heads[l] = succ[e];
            else succ[prev] = succ[e];
            succ[e] = free_top;
            free_top = LinkW'(e);
            owner[e] = RoleFree;
          end
        end
      end
      CmdKeys: begin
        dep[e] = dk;
        hgt[e] = hk;
      end
      CmdSort: begin
        if (l >= Lists) r.st = StMissing;
        else resort_list(l);
      end
      CmdHead: begin
        if (l >= Lists) r.st = StMissing;
        else if (heads[l] < Entries) begin
          r.idx = heads[l][5:0];
          r.pres = 1'b1;
        end
      end
      default: begin
        if (succ[e] < Entries) begin
          r.idx = succ[e][5:0];
          r.pres = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pool_result_t want;
    pool_result_t got;
    if (rst) begin
      for (int i = 0; i < Entries; i++) begin
        dep[i] = 0;
        hgt[i] = 0;
      end
      chain_free();
      awaited_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{st: status, idx: result_index, pres: result_present};
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result item: status %0d index %0d present %0d",
                     status, result_index, result_present);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       want.st, want.idx, want.pres, got.st, got.idx, got.pres);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_command(command, list_select, entry_index,
                                                depth_key, height_key));
    end
    pending_count <= awaited_results.size();
  end
endmodule

/* dv/depth_sorted_object_list_pool_core_tb.sv */
module depth_sorted_object_list_pool_core_tb;
  import dsol_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = CmdHead;
  logic [1:0] list_select = '0;
  logic [5:0] entry_index = '0;
  logic [31:0] depth_key = '0;
  logic [31:0] height_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [5:0] result_index;
  logic result_present;
  int fail_count;
  int pending_count;
  int sent_count = 0;
  // Entries the stimulus believes are allocated and unlisted; this steers the
  // random part towards well-formed key and insert runs.
  int spare_entries [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  depth_sorted_object_list_pool_core u_top (
    .clk, .rst, .in_valid, .in_stall, .command, .list_select, .entry_index,
    .depth_key, .height_key, .out_valid, .out_stall, .status, .result_index,
    .result_present
  );

  depth_sorted_object_list_pool_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .command, .list_select, .entry_index,
    .depth_key, .height_key, .out_valid, .out_stall, .status, .result_index,
    .result_present, .fail_count, .pending_count
  );

  // The receiving side stalls for a random number of cycles before each item,
  // and for some items it does not stall at all.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  // Sends one item and returns once the block has taken it. Valid stays high
  // between back-to-back items, so it is only ever assigned once per edge.
  task automatic send_item(logic [2:0] c, logic [1:0] l, logic [5:0] e,
                           logic [31:0] dk, logic [31:0] hk);
    int gap;
    gap = (sent_count % 200 < 40) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    list_select <= l;
    entry_index <= e;
    depth_key <= dk;
    height_key <= hk;
    @(posedge clk iff !in_stall);
    sent_count++;
  endtask

  // Keys are drawn either from a narrow range, so that ties on depth and height
  // occur often, or from the whole 32-bit range, extremes included.
  function automatic logic [31:0] draw_key();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  task automatic send_random();
    int pick;
    int e;
    pick = $urandom_range(0, 99);
    if (pick < 18)
      send_item(CmdAlloc, 2'($urandom), 6'($urandom), $urandom(), $urandom());
    else if (pick < 36 && spare_entries.size() > 0) begin
      e = spare_entries[$urandom_range(0, spare_entries.size() - 1)];
      send_item(CmdKeys, 2'($urandom), 6'(e), draw_key(), draw_key());
    end else if (pick < 54 && spare_entries.size() > 0) begin
      e = $urandom_range(0, spare_entries.size() - 1);
      send_item(CmdInsert, 2'($urandom), 6'(spare_entries[e]), $urandom(), $urandom());
      spare_entries.delete(e);
    end else if (pick < 68)
      send_item(CmdKeys, 2'($urandom), 6'($urandom), draw_key(), draw_key());
    else if (pick < 76)
      send_item(CmdSort, 2'($urandom), 6'($urandom), $urandom(), $urandom());
    else if (pick < 86)
      send_item(CmdDelete, 2'($urandom), 6'($urandom), $urandom(), $urandom());
    else if (pick < 99)
      send_item(3'($urandom_range(CmdHead, CmdNext)), 2'($urandom), 6'($urandom),
                $urandom(), $urandom());
    else begin
      send_item(CmdRebuild, 2'($urandom), 6'($urandom), $urandom(), $urandom());
      spare_entries.delete();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty reads, allocate, key extremes, insertion with ties,
    // ineligible inserts and deletes, a sort with disorder, and rebuild.
    send_item(CmdHead, 2'd3, 6'd0, '0, '0);
    send_item(CmdNext, 2'd0, 6'd63, '0, '0);
    send_item(CmdInsert, 2'd0, 6'd5, '0, '0);
    send_item(CmdAlloc, 2'd0, 6'd0, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CmdAlloc, 2'd0, 6'd0, '0, '0);
    send_item(CmdAlloc, 2'd0, 6'd0, '0, '0);
    send_item(CmdKeys, 2'd0, 6'd0, 32'h7fff_ffff, 32'h8000_0000);
    send_item(CmdKeys, 2'd0, 6'd1, 32'h8000_0000, 32'h7fff_ffff);
    send_item(CmdKeys, 2'd0, 6'd2, 32'h8000_0000, 32'h7fff_ffff);
    send_item(CmdInsert, 2'd0, 6'd0, '0, '0);
    send_item(CmdInsert, 2'd0, 6'd1, '0, '0);
    send_item(CmdInsert, 2'd0, 6'd2, '0, '0);
    send_item(CmdInsert, 2'd1, 6'd2, '0, '0);
    send_item(CmdHead, 2'd0, 6'd0, '0, '0);
    send_item(CmdNext, 2'd3, 6'd2, '0, '0);
    send_item(CmdKeys, 2'd0, 6'd2, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(CmdSort, 2'd0, 6'd0, '0, '0);
    send_item(CmdNext, 2'd0, 6'd0, '0, '0);
    send_item(CmdDelete, 2'd1, 6'd0, '0, '0);
    send_item(CmdDelete, 2'd0, 6'd1, '0, '0);
    send_item(CmdNext, 2'd0, 6'd1, '0, '0);
    send_item(CmdRebuild, 2'd2, 6'd0, '0, '0);
    send_item(CmdHead, 2'd0, 6'd0, '0, '0);

    // Drain the free list completely so that the empty pool is reported.
    repeat (65) send_item(CmdAlloc, 2'd1, 6'd0, '0, '0);
    send_item(CmdRebuild, 2'd0, 6'd0, '0, '0);

    // Hold off until every outstanding result has come back.
    in_valid <= 1'b0;
    @(posedge clk iff pending_count == 0);

    while (sent_count < 1650) begin
      send_random();
      // Allocations are tracked by watching the answer; an allocate that
      // succeeded hands its entry to the spare list for later key and insert.
      if (command == CmdAlloc) begin
        in_valid <= 1'b0;
        @(posedge clk iff pending_count == 0);
        if (result_present) spare_entries.push_back(int'(result_index));
      end
    end
    in_valid <= 1'b0;
    @(posedge clk iff pending_count == 0);
    repeat (200) @(posedge clk);

    $display("Sent %0d command items covering all eight commands, key extremes,", sent_count);
    $display("ties on depth and height, sorts of disordered lists and an empty pool.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
